### rtl/image_resample_nearest_bilinear_top_macros.svh
// Assertion helpers for the resampler top module.
`ifndef IMAGE_RESAMPLE_NEAREST_BILINEAR_TOP_MACROS_SVH
`define IMAGE_RESAMPLE_NEAREST_BILINEAR_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IRN_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IRN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/irn_pkg.sv
// ---------------------------------------------------------------------------
// irn_pkg
// Types and constants of the nearest / bilinear image resampler.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package irn_pkg;

    localparam logic [2:0] CFG_SRC_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_SRC_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_X_RATIO    = 3'd2;
    localparam logic [2:0] CFG_Y_RATIO    = 3'd3;
    localparam logic [2:0] CFG_METHOD     = 3'd4;

    localparam logic MODE_STORE   = 1'b0;
    localparam logic MODE_REQUEST = 1'b1;

    localparam logic METHOD_NEAREST  = 1'b0;
    localparam logic METHOD_BILINEAR = 1'b1;

    // coordinates in 2^-17 units
    localparam logic [33:0] HALF17 = 34'd65536;
    localparam logic [17:0] ONE17  = 18'd131072;

    typedef logic [8:0]  t_size;
    typedef logic [16:0] t_frac;

endpackage

### rtl/image_resample_nearest_bilinear_top.sv
// ---------------------------------------------------------------------------
// image_resample_nearest_bilinear_top
// Frame store plus nearest / bilinear resampling of single output pixels.
// ---------------------------------------------------------------------------
//  channel   handshake                  payload
//  input     i_in_valid / o_in_ready    i_mode i_column i_row i_channel i_pixel_in
//  output    o_out_valid / i_out_ready  o_pixel_out
//  config    i_cfg_we (no wait)         i_cfg_index i_cfg_data
//
//  Store item: written into the frame RAM at acceptance if its address is in range.
//  A request passes S_MUL and S_IDX; nearest then reads one pixel, bilinear reads
//  the four corners through the single read port and the multiply-accumulate
//  pipe. A missing channel yields 0. o_in_ready is low while a request is worked.
//  A finished result waits in the output register; a following request is taken
//  and worked, then holds before output until that register is free.
//  Reset (synchronous, active low) clears control; the frame RAM is not cleared.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module image_resample_nearest_bilinear_top #(
    parameter int MAX_WIDTH    = 256,
    parameter int MAX_HEIGHT   = 256,
    parameter int MAX_CHANNELS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_mode,
    input  logic [7:0]  i_column,
    input  logic [7:0]  i_row,
    input  logic [1:0]  i_channel,
    input  logic [7:0]  i_pixel_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_pixel_out
);

`include "image_resample_nearest_bilinear_top_macros.svh"

    localparam int PLANE = MAX_HEIGHT * MAX_WIDTH;
    localparam int DEPTH = MAX_CHANNELS * PLANE;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_IDX, S_READ, S_NWAIT, S_DRAIN, S_DONE
    } t_state;

    t_state r_state;

    logic [8:0]  r_src_w, r_src_h;
    logic [23:0] r_x_ratio, r_y_ratio;
    logic        r_method;

    logic [7:0]  r_col, r_row;
    logic [1:0]  r_ch;
    logic        r_bil;
    logic [32:0] r_ux, r_uy;
    irn_pkg::t_frac r_fx, r_fy;
    logic [AW-1:0] r_addr [4];
    logic [1:0]  r_idx;
    logic        r_iv, r_pv;
    logic [35:0] r_w;
    logic [43:0] r_prod, r_acc;
    logic [7:0]  r_res;
    logic        r_out_valid;
    logic [7:0]  r_pixel_out;

    logic        in_acc, store_ok, ram_we;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]  rdata;
    irn_pkg::t_size eff_w, eff_h;
    logic [33:0] tx, ty;
    logic [16:0] kx, ky;
    irn_pkg::t_size x0, x1, y0, y1, nx, ny;
    logic [17:0] wx, wy;
    logic [35:0] n_w;
    logic [43:0] rnd;
    logic [9:0]  rq;
    logic        out_free;

    function automatic logic [AW-1:0] f_addr(input logic [1:0] c, input logic [8:0] y,
                                             input logic [8:0] x);
        f_addr = AW'(c) * AW'(PLANE) + AW'(y) * AW'(MAX_WIDTH) + AW'(x);
    endfunction

    function automatic irn_pkg::t_size f_clamp(input logic [16:0] v, input irn_pkg::t_size s);
        f_clamp = (v >= {8'd0, s}) ? s - 9'd1 : v[8:0];
    endfunction

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_pixel_out = r_pixel_out;
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    always_comb begin
        store_ok = (32'(i_column) < MAX_WIDTH) && (32'(i_row) < MAX_HEIGHT)
                   && (32'(i_channel) < MAX_CHANNELS);
        ram_we = in_acc && (i_mode == irn_pkg::MODE_STORE) && store_ok;
        waddr  = f_addr(i_channel, {1'b0, i_row}, {1'b0, i_column});
        raddr  = r_addr[r_idx];

        if (r_src_w == 9'd0) eff_w = 9'd1;
        else if (32'(r_src_w) > MAX_WIDTH) eff_w = 9'(MAX_WIDTH);
        else eff_w = r_src_w;
        if (r_src_h == 9'd0) eff_h = 9'd1;
        else if (32'(r_src_h) > MAX_HEIGHT) eff_h = 9'(MAX_HEIGHT);
        else eff_h = r_src_h;

        tx = {1'b0, r_ux} + irn_pkg::HALF17;
        ty = {1'b0, r_uy} + irn_pkg::HALF17;
        kx = tx[33:17];
        ky = ty[33:17];
        x0 = (kx == 17'd0) ? 9'd0 : f_clamp(kx - 17'd1, eff_w);
        y0 = (ky == 17'd0) ? 9'd0 : f_clamp(ky - 17'd1, eff_h);
        x1 = f_clamp(kx, eff_w);
        y1 = f_clamp(ky, eff_h);
        nx = f_clamp({1'b0, r_ux[32:17]}, eff_w);
        ny = f_clamp({1'b0, r_uy[32:17]}, eff_h);

        // corner bit 0 picks the right column, bit 1 the lower row
        wx  = r_idx[0] ? {1'b0, r_fx} : irn_pkg::ONE17 - {1'b0, r_fx};
        wy  = r_idx[1] ? {1'b0, r_fy} : irn_pkg::ONE17 - {1'b0, r_fy};
        n_w = wx * wy;

        rnd = r_acc + (44'd1 << 33);
        rq  = rnd[43:34];
    end

    irn_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_frame (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(waddr),
        .i_wdata(i_pixel_in),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_src_w     <= 9'd256;
            r_src_h     <= 9'd256;
            r_x_ratio   <= 24'd65536;
            r_y_ratio   <= 24'd65536;
            r_method    <= irn_pkg::METHOD_BILINEAR;
            r_out_valid <= 1'b0;
            r_idx       <= 2'd0;
            r_iv        <= 1'b0;
            r_pv        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    irn_pkg::CFG_SRC_WIDTH:  r_src_w   <= i_cfg_data[8:0];
                    irn_pkg::CFG_SRC_HEIGHT: r_src_h   <= i_cfg_data[8:0];
                    irn_pkg::CFG_X_RATIO:    r_x_ratio <= i_cfg_data;
                    irn_pkg::CFG_Y_RATIO:    r_y_ratio <= i_cfg_data;
                    irn_pkg::CFG_METHOD:     r_method  <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (r_state == S_DONE && out_free) r_out_valid <= 1'b1;
            else if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;

            // multiply-accumulate pipe: read issue -> product -> accumulate
            r_iv   <= (r_state == S_READ) && r_bil;
            r_pv   <= r_iv;
            r_prod <= 44'(rdata) * 44'(r_w);
            if (r_pv) r_acc <= r_acc + r_prod;

            case (r_state)
                S_IDLE: begin
                    if (in_acc && i_mode == irn_pkg::MODE_REQUEST) begin
                        r_col <= i_column;
                        r_row <= i_row;
                        r_ch  <= i_channel;
                        r_bil <= (r_method == irn_pkg::METHOD_BILINEAR);
                        r_idx <= 2'd0;
                        r_acc <= 44'd0;
                        if (32'(i_channel) < MAX_CHANNELS) begin
                            r_state <= S_MUL;
                        end else begin
                            r_res   <= 8'd0;
                            r_state <= S_DONE;
                        end
                    end
                end
                S_MUL: begin
                    r_ux    <= 33'({r_col, 1'b1}) * 33'(r_x_ratio);
                    r_uy    <= 33'({r_row, 1'b1}) * 33'(r_y_ratio);
                    r_state <= S_IDX;
                end
                S_IDX: begin
                    r_fx <= tx[16:0];
                    r_fy <= ty[16:0];
                    if (r_bil) begin
                        r_addr[0] <= f_addr(r_ch, y0, x0);
                        r_addr[1] <= f_addr(r_ch, y0, x1);
                        r_addr[2] <= f_addr(r_ch, y1, x0);
                        r_addr[3] <= f_addr(r_ch, y1, x1);
                    end else begin
                        r_addr[0] <= f_addr(r_ch, ny, nx);
                    end
                    r_state <= S_READ;
                end
                S_READ: begin
                    if (r_bil) begin
                        r_w   <= n_w;
                        r_idx <= r_idx + 2'd1;
                        if (r_idx == 2'd3) r_state <= S_DRAIN;
                    end else begin
                        r_state <= S_NWAIT;
                    end
                end
                S_NWAIT: begin
                    r_res   <= rdata;
                    r_state <= S_DONE;
                end
                S_DRAIN: begin
                    if (!r_iv && !r_pv) begin
                        r_res   <= (rq > 10'd255) ? 8'd255 : rq[7:0];
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_pixel_out <= r_res;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `IRN_ASSERT_NEXT(a_req_busy, in_acc && i_mode == irn_pkg::MODE_REQUEST,
                     r_state != S_IDLE, "request did not leave idle")
    `IRN_ASSERT_NOW(a_we_idle, ram_we, r_state == S_IDLE, "frame write during a request")
    `IRN_ASSERT_NOW(a_pipe_bil, r_iv || r_pv,
                    r_bil && (r_state == S_READ || r_state == S_DRAIN),
                    "corner pipe active outside bilinear read")
    `IRN_ASSERT_NEXT(a_drain_end, r_state == S_READ && r_bil && r_idx == 2'd3,
                     r_state == S_DRAIN && r_iv, "fourth corner not issued")

endmodule

### rtl/irn_ram.sv
// ---------------------------------------------------------------------------
// irn_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module irn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 262144
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
